// ===== sv/sia_pkg.sv =====
// ----------------------------------------------------------------------------
// sia_pkg
// shared types, opcodes and sequencer states of the script integer alu
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int DataWidth = 32;
  localparam int CntWidth  = $clog2(DataWidth + 1);

  typedef logic signed [DataWidth-1:0] data_t;

  typedef enum logic [4:0] {
    OP_SET       = 5'd0,
    OP_SET_GT    = 5'd1,
    OP_SET_LT    = 5'd2,
    OP_SET_EQ    = 5'd3,
    OP_SET_NEQ   = 5'd4,
    OP_TEST      = 5'd5,
    OP_TEST_LE   = 5'd6,
    OP_TEST_EQ   = 5'd7,
    OP_ADD       = 5'd8,
    OP_SUB       = 5'd9,
    OP_MUL       = 5'd10,
    OP_AGGREGATE = 5'd11,
    OP_OFFSET    = 5'd12,
    OP_OFFSETMOD = 5'd13,
    OP_DIV       = 5'd14,
    OP_MOD       = 5'd15,
    OP_SHL       = 5'd16,
    OP_SHR       = 5'd17,
    OP_ABS       = 5'd18,
    OP_MIN       = 5'd19,
    OP_MAX       = 5'd20,
    OP_WAVE_RECT = 5'd21,
    OP_WAVE_SAW  = 5'd22,
    OP_WAVE_TRI  = 5'd23,
    OP_GET_COLOR = 5'd24,
    OP_SET_COLOR = 5'd25,
    OP_GET_SHADE = 5'd26,
    OP_SET_SHADE = 5'd27,
    OP_ADD_SHADE = 5'd28
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH,
    ST_OUT
  } state_t;

  localparam logic [7:0] NibbleMask = 8'h0F;
  localparam logic [7:0] HighMask   = 8'hF0;
  localparam logic [7:0] ShadeMin   = 8'h01;

endpackage

// ===== sv/sia_if.sv =====
// ----------------------------------------------------------------------------
// sia_req_if / sia_rsp_if
// valid/ready channels carrying request and result beats
// ----------------------------------------------------------------------------
interface sia_req_if
  import sia_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [4:0]  req_type;
  data_t       reg_value;
  data_t       arg_one;
  data_t       arg_two;
  data_t       arg_three;
  modport source (output valid, req_type, reg_value, arg_one, arg_two, arg_three,
                  input ready);
  modport sink (input valid, req_type, reg_value, arg_one, arg_two, arg_three,
                output ready);
endinterface

interface sia_rsp_if
  import sia_pkg::*;
();
  logic  valid;
  logic  ready;
  data_t result_value;
  logic  write_enable;
  logic  branch_taken;
  logic  op_error;
  modport source (output valid, result_value, write_enable, branch_taken, op_error,
                  input ready);
  modport sink (input valid, result_value, write_enable, branch_taken, op_error,
                output ready);
endinterface

// ===== sv/script_integer_alu_core.sv =====
// ----------------------------------------------------------------------------
// script_integer_alu_core
// integer alu of a script machine with a signed condition register
// ----------------------------------------------------------------------------
// sequence: accept, multiply state, finish state, result beat for plain ops and
// error cases; div, mod, offsetmod and wave ops add divider setup and 32 steps
// of the shared divider. flow: one beat at a time, ready again the cycle after
// the result is taken
// reset: synchronous, clears sequencer and condition register to zero
module script_integer_alu_core
  import sia_pkg::*;
(
  input logic clk,
  input logic rst,
  sia_req_if.sink   req,
  sia_rsp_if.source rsp
);

  sia_seq u_seq (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

endmodule

// ===== sv/sia_divider.sv =====
// ----------------------------------------------------------------------------
// sia_divider
// radix-2 restoring divider, truncating quotient and remainder, one bit a cycle
// ----------------------------------------------------------------------------
module sia_divider
  import sia_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  data_t dividend,
  input  data_t divisor,
  output logic  done,
  output data_t quotient,
  output data_t remainder
);

  logic [DataWidth-1:0] rem_q;
  logic [DataWidth-1:0] quo_q;
  logic [DataWidth-1:0] den;
  logic                 neg_q;
  logic                 neg_r;
  logic [CntWidth-1:0]  count;
  logic                 busy;
  logic [DataWidth:0]   trial;
  logic [DataWidth-1:0] shifted;

  assign shifted = {rem_q[DataWidth-2:0], quo_q[DataWidth-1]};
  assign trial   = {1'b0, shifted} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CntWidth'(DataWidth);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_q <= '0;
      quo_q <= dividend[DataWidth-1] ? -dividend : dividend;
      den   <= divisor[DataWidth-1] ? -divisor : divisor;
      neg_q <= dividend[DataWidth-1] ^ divisor[DataWidth-1];
      neg_r <= dividend[DataWidth-1];
    end else if (busy) begin
      if (!trial[DataWidth]) begin
        rem_q <= trial[DataWidth-1:0];
        quo_q <= {quo_q[DataWidth-2:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[DataWidth-2:0], 1'b0};
      end
    end
  end

  assign quotient  = neg_q ? -quo_q : quo_q;
  assign remainder = neg_r ? -rem_q : rem_q;

endmodule

// ===== sv/sia_seq.sv =====
// ----------------------------------------------------------------------------
// sia_seq
// sequencer: operand setup, multiply stage, divider control, result finish
// ----------------------------------------------------------------------------
module sia_seq
  import sia_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sia_req_if.sink   req,
  sia_rsp_if.source rsp
);

  state_t state, state_next;

  logic [4:0] op;
  data_t      r, a, b, c;
  data_t      prod;
  data_t      cond;
  data_t      res;
  logic       we, br, err;
  data_t      div_n, div_d;
  logic       div_start, div_done;
  data_t      quo, remd;

  sia_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n), .divisor(div_d),
    .done(div_done), .quotient(quo), .remainder(remd)
  );

  logic is_div;
  logic is_wave;
  logic div_err;

  assign is_wave = (op == OP_WAVE_RECT) || (op == OP_WAVE_SAW) || (op == OP_WAVE_TRI);
  assign is_div  = (op == OP_DIV) || (op == OP_MOD) || (op == OP_OFFSETMOD) || is_wave;
  assign div_err = (op == OP_OFFSETMOD) ? (c == 0) :
                   is_wave ? (a <= 0) : (a == 0);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (req.valid) state_next = ST_MUL;
      ST_MUL:       state_next = is_div ? (div_err ? ST_FINISH : ST_DIV_START) : ST_FINISH;
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (div_done) state_next = ST_FINISH;
      ST_FINISH:    state_next = ST_OUT;
      ST_OUT:       if (rsp.ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == ST_IDLE);
    rsp.valid = (state == ST_OUT);
    div_start = (state == ST_DIV_START);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op <= req.req_type;
      r  <= req.reg_value;
      a  <= req.arg_one;
      b  <= req.arg_two;
      c  <= req.arg_three;
    end
  end

  // single shared multiplier
  data_t mul_x, mul_y;
  always_comb begin
    case (op)
      OP_AGGREGATE: begin mul_x = a; mul_y = b; end
      default:      begin mul_x = r; mul_y = a; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) prod <= DataWidth'(mul_x * mul_y);
  end

  always_comb begin
    case (op)
      OP_OFFSETMOD: begin div_n = prod + b; div_d = c; end
      default:      begin div_n = r; div_d = a; end
    endcase
  end

  // finish
  data_t t, p, half, pp;
  data_t sum;
  logic signed [DataWidth:0] s;
  logic [4:0] sh;
  data_t res_c;
  logic  we_c, br_c, err_c;

  always_comb begin
    res_c = r;
    we_c  = 1'b1;
    br_c  = 1'b0;
    err_c = 1'b0;
    sh    = a[4:0];
    t     = remd;
    p     = remd;
    half  = b >>> 1;
    pp    = '0;
    sum   = '0;
    s     = '0;
    if (b[DataWidth-1] && b[0]) half = half + 1'b1;
    case (op)
      OP_SET:       res_c = a;
      OP_SET_GT:    begin we_c = cond > 0;  res_c = a; end
      OP_SET_LT:    begin we_c = cond < 0;  res_c = a; end
      OP_SET_EQ:    begin we_c = cond == 0; res_c = a; end
      OP_SET_NEQ:   begin we_c = cond != 0; res_c = a; end
      OP_TEST:      we_c = 1'b0;
      OP_TEST_LE:   begin we_c = 1'b0; br_c = a <= b; end
      OP_TEST_EQ:   begin we_c = 1'b0; br_c = a == b; end
      OP_ADD:       res_c = r + a;
      OP_SUB:       res_c = r - a;
      OP_MUL:       res_c = prod;
      OP_AGGREGATE: res_c = r + prod;
      OP_OFFSET:    res_c = prod + b;
      OP_OFFSETMOD: begin
        if (c == 0) begin err_c = 1'b1; we_c = 1'b0; end
        else begin
          if (t != 0 && (t[DataWidth-1] != c[DataWidth-1])) t = t + c;
          res_c = t;
        end
      end
      OP_DIV: begin
        if (a == 0) begin err_c = 1'b1; we_c = 1'b0; end
        else res_c = quo;
      end
      OP_MOD: begin
        if (a == 0) begin err_c = 1'b1; we_c = 1'b0; end
        else res_c = remd;
      end
      OP_SHL:       res_c = r << sh;
      OP_SHR:       res_c = r >>> sh;
      OP_ABS:       res_c = r[DataWidth-1] ? -r : r;
      OP_MIN:       res_c = (r < a) ? r : a;
      OP_MAX:       res_c = (r > a) ? r : a;
      OP_WAVE_RECT, OP_WAVE_SAW, OP_WAVE_TRI: begin
        if (a <= 0) begin err_c = 1'b1; we_c = 1'b0; end
        else begin
          if (p[DataWidth-1]) p = p + a;
          if (p > b) res_c = '0;
          else if (op == OP_WAVE_RECT) res_c = c;
          else begin
            pp = p;
            if (op == OP_WAVE_TRI && p > half) pp = b - p;
            res_c = (pp > c) ? c : pp;
          end
        end
      end
      OP_GET_COLOR: res_c = a >>> 4;
      OP_SET_COLOR: res_c = (r & DataWidth'(NibbleMask)) | (a << 4);
      OP_GET_SHADE: res_c = a & DataWidth'(NibbleMask);
      OP_SET_SHADE: res_c = (r & DataWidth'(HighMask)) | (a & DataWidth'(NibbleMask));
      OP_ADD_SHADE: begin
        s = {{(DataWidth-3){1'b0}}, r[3:0]} + {a[DataWidth-1], a};
        sum = r & DataWidth'(HighMask);
        if (a > 15 || s > 15) res_c = DataWidth'(NibbleMask);
        else if (s > 0) res_c = sum | DataWidth'(s[DataWidth-1:0]);
        else if (sum == 0 || s < 0) res_c = DataWidth'(ShadeMin);
        else res_c = sum;
      end
      default:      we_c = 1'b0;
    endcase
    if (!we_c) res_c = r;
  end

  always_ff @(posedge clk) begin
    if (rst) cond <= '0;
    else if (state == ST_FINISH && op == OP_TEST) cond <= a - b;
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      res <= res_c;
      we  <= we_c;
      br  <= br_c;
      err <= err_c;
    end
  end

  assign rsp.result_value = res;
  assign rsp.write_enable = we;
  assign rsp.branch_taken = br;
  assign rsp.op_error     = err;

endmodule

// ===== sv/sia_checker.sv =====
// ----------------------------------------------------------------------------
// sia_checker
// port-level checks of the script integer alu
// ----------------------------------------------------------------------------
module sia_checker
  import sia_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input data_t rsp_result_value,
  input logic rsp_write_enable,
  input logic rsp_branch_taken,
  input logic rsp_op_error
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("accepting while a result waits");

  a_err_no_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_op_error |-> !rsp_write_enable && !rsp_branch_taken)
    else $error("error beat with write or branch");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready right after accept");

endmodule

bind script_integer_alu_core sia_checker u_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_result_value(rsp.result_value), .rsp_write_enable(rsp.write_enable),
  .rsp_branch_taken(rsp.branch_taken), .rsp_op_error(rsp.op_error)
);
